// File: rtl/core/pfws_pkg.sv
// Package for the parallel flash write sequencer: beat payload types,
// result kind and burst codes, and the per-burst beat table. No dependencies.
`default_nettype none

package pfws_pkg;

  // Request functions
  localparam logic [1:0] FN_ERASE  = 2'd0;
  localparam logic [1:0] FN_PROG   = 2'd1;
  localparam logic [1:0] FN_VERIFY = 2'd2;
  localparam logic [1:0] FN_RDATA  = 2'd3;

  // Result kinds
  localparam logic [2:0] K_WRITE       = 3'd0;
  localparam logic [2:0] K_READ        = 3'd1;
  localparam logic [2:0] K_OK          = 3'd2;
  localparam logic [2:0] K_ERASE_FAIL  = 3'd3;
  localparam logic [2:0] K_VERIFY_FAIL = 3'd4;

  // Burst codes: one code per sequence of result beats
  localparam logic [3:0] B_READ    = 4'd0;
  localparam logic [3:0] B_OK      = 4'd1;
  localparam logic [3:0] B_EFAIL   = 4'd2;
  localparam logic [3:0] B_VFAIL   = 4'd3;
  localparam logic [3:0] B_ERASE28 = 4'd4;
  localparam logic [3:0] B_ERASE29 = 4'd5;
  localparam logic [3:0] B_PROG28  = 4'd6;
  localparam logic [3:0] B_PROG29  = 4'd7;
  localparam logic [3:0] B_ALT     = 4'd8;

  // Address sources
  localparam logic [1:0] A_5555 = 2'd0;
  localparam logic [1:0] A_2AAA = 2'd1;
  localparam logic [1:0] A_CUR  = 2'd2;

  // Data sources
  localparam logic [1:0] D_CONST = 2'd0;
  localparam logic [1:0] D_CUR   = 2'd1;
  localparam logic [1:0] D_RD    = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [19:0] offset;
    logic [7:0]  wdata;
    logic [7:0]  rdata;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [19:0] bus_addr;
    logic [7:0]  bus_data;
    logic [7:0]  expected;
    logic        last;
  } out_item_t;

  // One entry of the beat table
  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] asel;
    logic [1:0] dsel;
    logic [7:0] cbyte;
    logic       exp_cur;
    logic       last;
  } beat_t;

  function automatic beat_t mk(input logic [2:0] kind, input logic [1:0] asel,
                               input logic [1:0] dsel, input logic [7:0] cbyte);
    beat_t b;
    b.kind    = kind;
    b.asel    = asel;
    b.dsel    = dsel;
    b.cbyte   = cbyte;
    b.exp_cur = 1'b0;
    b.last    = 1'b0;
    return b;
  endfunction

  // Index of the final beat of each burst
  function automatic logic [3:0] burst_end(input logic [3:0] burst);
    logic [3:0] n;
    case (burst)
      B_ERASE28: n = 4'd2;
      B_ERASE29: n = 4'd6;
      B_PROG28:  n = 4'd2;
      B_PROG29:  n = 4'd4;
      B_ALT:     n = 4'd9;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

  // Beat table: what beat number idx of a burst puts on the bus
  function automatic beat_t beat(input logic [3:0] burst, input logic [3:0] idx);
    beat_t b;
    b = mk(K_READ, A_CUR, D_CONST, 8'h00);
    case (burst)
      B_OK:    b = mk(K_OK, A_CUR, D_CONST, 8'h00);
      B_EFAIL: b = mk(K_ERASE_FAIL, A_CUR, D_RD, 8'h00);
      B_VFAIL: begin
        b = mk(K_VERIFY_FAIL, A_CUR, D_RD, 8'h00);
        b.exp_cur = 1'b1;
      end
      B_ERASE28: begin
        case (idx)
          4'd0:    b = mk(K_WRITE, A_5555, D_CONST, 8'h20);
          4'd1:    b = mk(K_WRITE, A_CUR, D_CONST, 8'hD0);
          default: b = mk(K_READ, A_CUR, D_CONST, 8'h00);
        endcase
      end
      B_ERASE29: begin
        case (idx)
          4'd0:    b = mk(K_WRITE, A_5555, D_CONST, 8'hAA);
          4'd1:    b = mk(K_WRITE, A_2AAA, D_CONST, 8'h55);
          4'd2:    b = mk(K_WRITE, A_5555, D_CONST, 8'h80);
          4'd3:    b = mk(K_WRITE, A_5555, D_CONST, 8'hAA);
          4'd4:    b = mk(K_WRITE, A_2AAA, D_CONST, 8'h55);
          4'd5:    b = mk(K_WRITE, A_CUR, D_CONST, 8'h50);
          default: b = mk(K_READ, A_CUR, D_CONST, 8'h00);
        endcase
      end
      B_PROG28: begin
        case (idx)
          4'd0:    b = mk(K_WRITE, A_5555, D_CONST, 8'h10);
          4'd1:    b = mk(K_WRITE, A_CUR, D_CUR, 8'h00);
          default: b = mk(K_READ, A_CUR, D_CONST, 8'h00);
        endcase
      end
      B_PROG29: begin
        case (idx)
          4'd0:    b = mk(K_WRITE, A_5555, D_CONST, 8'hAA);
          4'd1:    b = mk(K_WRITE, A_2AAA, D_CONST, 8'h55);
          4'd2:    b = mk(K_WRITE, A_5555, D_CONST, 8'hA0);
          4'd3:    b = mk(K_WRITE, A_CUR, D_CUR, 8'h00);
          default: b = mk(K_READ, A_CUR, D_CONST, 8'h00);
        endcase
      end
      B_ALT: begin
        case (idx)
          4'd0:    b = mk(K_WRITE, A_5555, D_CONST, 8'hAA);
          4'd1:    b = mk(K_WRITE, A_2AAA, D_CONST, 8'h55);
          4'd2:    b = mk(K_WRITE, A_5555, D_CONST, 8'hF0);
          4'd3:    b = mk(K_WRITE, A_5555, D_CONST, 8'hAA);
          4'd4:    b = mk(K_WRITE, A_2AAA, D_CONST, 8'h55);
          4'd5:    b = mk(K_WRITE, A_5555, D_CONST, 8'h80);
          4'd6:    b = mk(K_WRITE, A_5555, D_CONST, 8'hAA);
          4'd7:    b = mk(K_WRITE, A_2AAA, D_CONST, 8'h55);
          4'd8:    b = mk(K_WRITE, A_CUR, D_CONST, 8'h30);
          default: b = mk(K_READ, A_CUR, D_CONST, 8'h00);
        endcase
      end
      default: b = mk(K_READ, A_CUR, D_CONST, 8'h00);
    endcase
    b.last = (idx == burst_end(burst));
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/parallel_flash_write_sequencer.sv
// Parallel NOR flash write sequencer, top level.
// Uses pfws_pkg for payload types, codes and the beat table.
`default_nettype none

// An accepted beat is decoded in the cycle it arrives: the sequencing state
// moves on at once and a burst descriptor is loaded into the result register.
// The result side then plays the burst out one beat per cycle while out_stall
// is low, from one beat (a read, a status) up to ten (the alternate erase with
// chip reset). The next input beat is taken in the same cycle as the final
// result beat of the current burst; beats that give no result (a request while
// busy, read data while idle) are taken every cycle while no burst is pending.
// The command set register may only be written while no burst is pending.
module parallel_flash_write_sequencer #(
  parameter int ADDR_BITS   = 20,
  parameter int ERASE_TRIES = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  pfws_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output pfws_pkg::out_item_t  out_data,
  input  wire                  cfg_we,
  input  wire                  cfg_wdata
);

  localparam int AW = (ADDR_BITS < 20) ? ADDR_BITS : 20;
  localparam int BW = AW - 12;
  localparam int TW = $clog2(ERASE_TRIES + 1);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_CHECK = 2'd1;
  localparam logic [1:0] PH_REF   = 2'd2;
  localparam logic [1:0] PH_POLL  = 2'd3;

  // Sequencing state
  logic             use28_r;
  logic [1:0]       phase_r, phase_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [AW-1:0]    cur_addr_r, cur_addr_nxt;
  logic [7:0]       cur_data_r, cur_data_nxt;
  logic             tref_r, tref_nxt;
  logic [1:0]       polls_r, polls_nxt;
  logic             tried_alt_r, tried_alt_nxt;
  logic [BW-1:0]    blk_r, blk_nxt;
  logic             blk_valid_r, blk_valid_nxt;
  logic [TW-1:0]    tries_r, tries_nxt;

  // Burst descriptor (result register)
  logic             busy_r, busy_nxt;
  logic [3:0]       burst_r, burst_nxt;
  logic [3:0]       step_r, step_nxt;
  logic [AW-1:0]    baddr_r;
  logic [7:0]       bdata_r;
  logic [7:0]       brd_r;

  logic             in_fire, out_fire, load;
  logic [3:0]       new_burst;
  logic [AW-1:0]    in_addr;
  logic [BW-1:0]    cur_blk;
  logic             tbit;
  pfws_pkg::beat_t  bt;
  logic [AW-1:0]    asel;
  logic [7:0]       dsel;

  assign in_addr = in_data.offset[AW-1:0];
  assign cur_blk = cur_addr_r[AW-1:12];
  assign tbit    = in_data.rdata[6];

  // Handshake: take a new beat when no burst is pending or its final beat is accepted
  assign bt        = pfws_pkg::beat(burst_r, step_r);
  assign out_valid = busy_r;
  assign out_fire  = busy_r && !out_stall;
  assign in_stall  = busy_r && !(out_fire && bt.last);
  assign in_fire   = in_valid && !in_stall;

  // Decode of one accepted beat
  always_comb begin
    phase_nxt     = phase_r;
    op_nxt        = op_r;
    cur_addr_nxt  = cur_addr_r;
    cur_data_nxt  = cur_data_r;
    tref_nxt      = tref_r;
    polls_nxt     = polls_r;
    tried_alt_nxt = tried_alt_r;
    blk_nxt       = blk_r;
    blk_valid_nxt = blk_valid_r;
    tries_nxt     = tries_r;
    load          = 1'b0;
    new_burst     = pfws_pkg::B_READ;
    if (in_data.func != pfws_pkg::FN_RDATA) begin
      // new request, dropped while busy
      if (phase_r == PH_IDLE) begin
        op_nxt       = in_data.func;
        cur_addr_nxt = in_addr;
        cur_data_nxt = in_data.wdata;
        phase_nxt    = PH_CHECK;
        load         = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_CHECK: begin
          load = 1'b1;
          if (op_r == pfws_pkg::FN_ERASE) begin
            if (in_data.rdata == 8'hFF) begin
              phase_nxt = PH_IDLE;
              new_burst = pfws_pkg::B_OK;
            end else if (blk_valid_r && (cur_blk == blk_r) && (tries_r <= TW'(1))) begin
              // tries for this block used up
              tries_nxt     = '0;
              blk_valid_nxt = 1'b0;
              phase_nxt     = PH_IDLE;
              new_burst     = pfws_pkg::B_EFAIL;
            end else begin
              if (blk_valid_r && (cur_blk == blk_r)) begin
                tries_nxt = tries_r - TW'(1);
              end else begin
                tries_nxt     = TW'(ERASE_TRIES);
                blk_nxt       = cur_blk;
                blk_valid_nxt = 1'b1;
              end
              tried_alt_nxt = 1'b0;
              phase_nxt     = PH_REF;
              new_burst     = use28_r ? pfws_pkg::B_ERASE28 : pfws_pkg::B_ERASE29;
            end
          end else if (op_r == pfws_pkg::FN_PROG) begin
            if (in_data.rdata == cur_data_r) begin
              phase_nxt = PH_IDLE;
              new_burst = pfws_pkg::B_OK;
            end else begin
              phase_nxt = PH_REF;
              new_burst = use28_r ? pfws_pkg::B_PROG28 : pfws_pkg::B_PROG29;
            end
          end else begin
            phase_nxt = PH_IDLE;
            new_burst = (in_data.rdata == cur_data_r) ? pfws_pkg::B_OK : pfws_pkg::B_VFAIL;
          end
        end
        PH_REF: begin
          tref_nxt  = tbit;
          polls_nxt = 2'd0;
          phase_nxt = PH_POLL;
          load      = 1'b1;
        end
        PH_POLL: begin
          load = 1'b1;
          if (tbit != tref_r) begin
            // still toggling: poll again
            tref_nxt = ~tref_r;
            if (polls_r != 2'd3) begin
              polls_nxt = polls_r + 2'd1;
            end
          end else if (op_r == pfws_pkg::FN_ERASE) begin
            if (!use28_r && !tried_alt_r && (polls_r != 2'd3)) begin
              tried_alt_nxt = 1'b1;
              phase_nxt     = PH_REF;
              new_burst     = pfws_pkg::B_ALT;
            end else begin
              phase_nxt = PH_CHECK;
            end
          end else begin
            phase_nxt = PH_IDLE;
            new_burst = pfws_pkg::B_OK;
          end
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
  end

  // Burst descriptor control
  always_comb begin
    busy_nxt  = busy_r;
    burst_nxt = burst_r;
    step_nxt  = step_r;
    if (out_fire) begin
      if (bt.last) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 4'd1;
      end
    end
    if (in_fire && load) begin
      busy_nxt  = 1'b1;
      burst_nxt = new_burst;
      step_nxt  = 4'd0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use28_r     <= 1'b0;
      phase_r     <= PH_IDLE;
      op_r        <= 2'd0;
      tref_r      <= 1'b0;
      polls_r     <= 2'd0;
      tried_alt_r <= 1'b0;
      blk_r       <= '0;
      blk_valid_r <= 1'b0;
      tries_r     <= TW'(ERASE_TRIES);
      busy_r      <= 1'b0;
      burst_r     <= pfws_pkg::B_READ;
      step_r      <= 4'd0;
    end else begin
      if (cfg_we) begin
        use28_r <= cfg_wdata;
      end
      if (in_fire) begin
        phase_r     <= phase_nxt;
        op_r        <= op_nxt;
        tref_r      <= tref_nxt;
        polls_r     <= polls_nxt;
        tried_alt_r <= tried_alt_nxt;
        blk_r       <= blk_nxt;
        blk_valid_r <= blk_valid_nxt;
        tries_r     <= tries_nxt;
      end
      busy_r  <= busy_nxt;
      burst_r <= burst_nxt;
      step_r  <= step_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_addr_r <= cur_addr_nxt;
      cur_data_r <= cur_data_nxt;
    end
    if (in_fire && load) begin
      baddr_r <= cur_addr_nxt;
      bdata_r <= cur_data_nxt;
      brd_r   <= in_data.rdata;
    end
  end

  // Result beat from the table entry
  always_comb begin
    case (bt.asel)
      pfws_pkg::A_5555: asel = AW'(16'h5555);
      pfws_pkg::A_2AAA: asel = AW'(16'h2AAA);
      default:          asel = baddr_r;
    endcase
    case (bt.dsel)
      pfws_pkg::D_CUR: dsel = bdata_r;
      pfws_pkg::D_RD:  dsel = brd_r;
      default:         dsel = bt.cbyte;
    endcase
    out_data.kind     = bt.kind;
    out_data.bus_addr = 20'(asel);
    out_data.bus_data = dsel;
    out_data.expected = bt.exp_cur ? bdata_r : 8'h00;
    out_data.last     = bt.last;
  end

  // Checks
  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall) else $error("input stalled with no burst pending");

  a_reset_clears_burst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("burst pending after reset");

  a_tries_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    tries_r <= TW'(ERASE_TRIES)) else $error("erase try count out of range");

  a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_data.last && !in_fire |=> !out_valid)
    else $error("burst continued past its final beat");

endmodule

`default_nettype wire

// File: sim/parallel_flash_write_sequencer_tb.sv
// Self-checking testbench for parallel_flash_write_sequencer: flash requests and
// read-back beats are streamed in, and every bus beat is checked against a predictor.
// Depends on pfws_pkg and the sequencer RTL only.
`default_nettype none

module parallel_flash_write_sequencer_tb;

  localparam int ERASE_TRIES = 4;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;

  // Flash command addresses and bytes
  localparam logic [19:0] ADDR_UNLOCK1 = 20'h05555;
  localparam logic [19:0] ADDR_UNLOCK2 = 20'h02AAA;
  localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
  localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
  localparam logic [7:0] CMD_SETUP = 8'h80;
  localparam logic [7:0] CMD_ERASE29 = 8'h50;
  localparam logic [7:0] CMD_ALT_ERASE = 8'h30;
  localparam logic [7:0] CMD_PROG29 = 8'hA0;
  localparam logic [7:0] CMD_ERASE28 = 8'h20;
  localparam logic [7:0] CMD_CONFIRM28 = 8'hD0;
  localparam logic [7:0] CMD_PROG28 = 8'h10;
  localparam logic [7:0] CMD_RESET = 8'hF0;
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_REF, ST_POLL} seq_phase_t;

  typedef struct {
    seq_phase_t  ph;
    logic [1:0]  op;
    logic [19:0] addr;
    logic [7:0]  data;
    logic        tref;
    logic [1:0]  polls;
    logic        alt_done;
    logic [7:0]  blk;
    logic        blk_valid;
    logic [2:0]  tries;
    logic        cmd28;
  } seq_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pfws_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pfws_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  pfws_pkg::in_item_t pending_q[$];
  pfws_pkg::out_item_t bus_beats_q[$];
  seq_state_t flash_model;
  seq_state_t stim_state;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int errors = 0;
  int cycle_cnt = 0;
  int beats_in = 0;
  int rdata_in = 0;
  int beats_checked = 0;
  int kind_cnt[5] = '{default: 0};

  parallel_flash_write_sequencer #(
    .ADDR_BITS(20),
    .ERASE_TRIES(ERASE_TRIES)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Sequencer state after reset
  function automatic seq_state_t reset_state();
    seq_state_t s;
    s.ph = ST_IDLE;
    s.op = pfws_pkg::FN_ERASE;
    s.addr = '0;
    s.data = '0;
    s.tref = 1'b0;
    s.polls = '0;
    s.alt_done = 1'b0;
    s.blk = '0;
    s.blk_valid = 1'b0;
    s.tries = 3'(ERASE_TRIES);
    s.cmd28 = 1'b0;
    return s;
  endfunction

  function automatic void add_beat(inout pfws_pkg::out_item_t [9:0] r, inout int n,
                                   input logic [2:0] k,
                                   input logic [19:0] a, input logic [7:0] d,
                                   input logic [7:0] e);
    r[n].kind = k;
    r[n].bus_addr = a;
    r[n].bus_data = d;
    r[n].expected = e;
    r[n].last = 1'b0;
    n = n + 1;
  endfunction

  function automatic void add_unlock(inout pfws_pkg::out_item_t [9:0] r, inout int n);
    add_beat(r, n, pfws_pkg::K_WRITE, ADDR_UNLOCK1, CMD_UNLOCK1, 8'h00);
    add_beat(r, n, pfws_pkg::K_WRITE, ADDR_UNLOCK2, CMD_UNLOCK2, 8'h00);
  endfunction

  // Predicts the bus beats caused by one accepted input beat; returns their number
  function automatic int flash_bus_beats(inout seq_state_t s, input pfws_pkg::in_item_t it,
                                         output pfws_pkg::out_item_t [9:0] r);
    int n;
    n = 0;
    r = '0;
    if (it.func != pfws_pkg::FN_RDATA) begin
      // new request, dropped while busy
      if (s.ph != ST_IDLE) return 0;
      s.op = it.func;
      s.addr = it.offset;
      s.data = it.wdata;
      s.ph = ST_CHECK;
      add_beat(r, n, pfws_pkg::K_READ, s.addr, 8'h00, 8'h00);
    end else if (s.ph == ST_CHECK) begin
      if (s.op == pfws_pkg::FN_ERASE) begin
        if (it.rdata == ERASED_BYTE) begin
          s.ph = ST_IDLE;
          add_beat(r, n, pfws_pkg::K_OK, s.addr, 8'h00, 8'h00);
        end else if (s.blk_valid && s.blk == s.addr[19:12] && s.tries <= 3'd1) begin
          // out of erase attempts for this 4K block
          s.tries = '0;
          s.blk_valid = 1'b0;
          s.ph = ST_IDLE;
          add_beat(r, n, pfws_pkg::K_ERASE_FAIL, s.addr, it.rdata, 8'h00);
        end else begin
          if (s.blk_valid && s.blk == s.addr[19:12]) begin
            s.tries = s.tries - 3'd1;
          end else begin
            s.tries = 3'(ERASE_TRIES);
            s.blk = s.addr[19:12];
            s.blk_valid = 1'b1;
          end
          s.alt_done = 1'b0;
          if (s.cmd28) begin
            add_beat(r, n, pfws_pkg::K_WRITE, ADDR_UNLOCK1, CMD_ERASE28, 8'h00);
            add_beat(r, n, pfws_pkg::K_WRITE, s.addr, CMD_CONFIRM28, 8'h00);
          end else begin
            add_unlock(r, n);
            add_beat(r, n, pfws_pkg::K_WRITE, ADDR_UNLOCK1, CMD_SETUP, 8'h00);
            add_unlock(r, n);
            add_beat(r, n, pfws_pkg::K_WRITE, s.addr, CMD_ERASE29, 8'h00);
          end
          add_beat(r, n, pfws_pkg::K_READ, s.addr, 8'h00, 8'h00);
          s.ph = ST_REF;
        end
      end else if (s.op == pfws_pkg::FN_PROG) begin
        if (it.rdata == s.data) begin
          // byte already holds the value
          s.ph = ST_IDLE;
          add_beat(r, n, pfws_pkg::K_OK, s.addr, 8'h00, 8'h00);
        end else begin
          if (s.cmd28) begin
            add_beat(r, n, pfws_pkg::K_WRITE, ADDR_UNLOCK1, CMD_PROG28, 8'h00);
          end else begin
            add_unlock(r, n);
            add_beat(r, n, pfws_pkg::K_WRITE, ADDR_UNLOCK1, CMD_PROG29, 8'h00);
          end
          add_beat(r, n, pfws_pkg::K_WRITE, s.addr, s.data, 8'h00);
          add_beat(r, n, pfws_pkg::K_READ, s.addr, 8'h00, 8'h00);
          s.ph = ST_REF;
        end
      end else begin
        s.ph = ST_IDLE;
        if (it.rdata == s.data) add_beat(r, n, pfws_pkg::K_OK, s.addr, 8'h00, 8'h00);
        else add_beat(r, n, pfws_pkg::K_VERIFY_FAIL, s.addr, it.rdata, s.data);
      end
    end else if (s.ph == ST_REF) begin
      s.tref = it.rdata[6];
      s.polls = '0;
      s.ph = ST_POLL;
      add_beat(r, n, pfws_pkg::K_READ, s.addr, 8'h00, 8'h00);
    end else if (s.ph == ST_POLL) begin
      if (it.rdata[6] != s.tref) begin
        // still toggling
        s.tref = ~s.tref;
        if (s.polls < 2'd3) s.polls = s.polls + 2'd1;
        add_beat(r, n, pfws_pkg::K_READ, s.addr, 8'h00, 8'h00);
      end else if (s.op == pfws_pkg::FN_ERASE) begin
        if (!s.cmd28 && !s.alt_done && s.polls < 2'd3) begin
          // settled too soon: chip reset, then the alternate block erase
          s.alt_done = 1'b1;
          add_unlock(r, n);
          add_beat(r, n, pfws_pkg::K_WRITE, ADDR_UNLOCK1, CMD_RESET, 8'h00);
          add_unlock(r, n);
          add_beat(r, n, pfws_pkg::K_WRITE, ADDR_UNLOCK1, CMD_SETUP, 8'h00);
          add_unlock(r, n);
          add_beat(r, n, pfws_pkg::K_WRITE, s.addr, CMD_ALT_ERASE, 8'h00);
          add_beat(r, n, pfws_pkg::K_READ, s.addr, 8'h00, 8'h00);
          s.ph = ST_REF;
        end else begin
          add_beat(r, n, pfws_pkg::K_READ, s.addr, 8'h00, 8'h00);
          s.ph = ST_CHECK;
        end
      end else begin
        s.ph = ST_IDLE;
        add_beat(r, n, pfws_pkg::K_OK, s.addr, 8'h00, 8'h00);
      end
    end else begin
      // read data while idle
      return 0;
    end
    r[n - 1].last = 1'b1;
    return n;
  endfunction

  // Picks the next input beat, mostly what the sequencer is waiting for
  function automatic pfws_pkg::in_item_t pick_stim(input seq_state_t g);
    pfws_pkg::in_item_t it;
    it.func = 2'($urandom_range(2));
    it.offset = 20'($urandom_range(20'hFFFFF));
    it.wdata = 8'($urandom_range(255));
    it.rdata = 8'($urandom_range(255));
    if (g.ph == ST_IDLE) begin
      if ($urandom_range(7) == 0) begin
        it.func = pfws_pkg::FN_RDATA;
      end else if (it.func == pfws_pkg::FN_ERASE && $urandom_range(3) != 0) begin
        // keep erases within a few blocks so retries pile up
        case ($urandom_range(3))
          0: it.offset[19:12] = 8'h00;
          1: it.offset[19:12] = 8'hFF;
          2: it.offset[19:12] = 8'hA5;
          default: it.offset[19:12] = g.blk;
        endcase
      end
    end else if ($urandom_range(11) != 0) begin
      it.func = pfws_pkg::FN_RDATA;
      case (g.ph)
        ST_CHECK: begin
          if (g.op == pfws_pkg::FN_ERASE) begin
            if ($urandom_range(3) == 0) it.rdata = ERASED_BYTE;
          end else if ($urandom_range(1) == 0) begin
            it.rdata = g.data;
          end
        end
        ST_POLL: it.rdata[6] = g.tref ^ ($urandom_range(99) < 55);
        default: ;
      endcase
    end
    return it;
  endfunction

  // Queues one input beat and advances the stimulus copy of the state
  task automatic offer(input pfws_pkg::in_item_t it, output int n);
    pfws_pkg::out_item_t [9:0] unused;
    n = flash_bus_beats(stim_state, it, unused);
    pending_q.push_back(it);
  endtask

  task automatic direct(input logic [1:0] f, input logic [19:0] o, input logic [7:0] w,
                        input logic [7:0] r);
    pfws_pkg::in_item_t it;
    int n;
    it.func = f;
    it.offset = o;
    it.wdata = w;
    it.rdata = r;
    offer(it, n);
  endtask

  // Random beats until enough have effect, then finish the open operation
  task automatic queue_ops(input int want);
    int got;
    int n;
    got = 0;
    while (got < want || stim_state.ph != ST_IDLE) begin
      offer(pick_stim(stim_state), n);
      if (n > 0) got++;
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || bus_beats_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_cmd_set(input logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    flash_model.cmd28 = v;
    stim_state.cmd28 = v;
  endtask

  task automatic report_mismatch(input string what, input logic [19:0] got,
                                 input logic [19:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
    errors++;
  endtask

  // Driver: offers queued beats, predicts on each accepted one
  always @(posedge clk) begin : drive
    int n;
    pfws_pkg::out_item_t [9:0] beats;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        n = flash_bus_beats(flash_model, in_data, beats);
        for (int i = 0; i < n; i++) bus_beats_q.push_back(beats[i]);
        beats_in++;
        if (in_data.func == pfws_pkg::FN_RDATA) rdata_in++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: each accepted result beat against the oldest prediction
  always @(posedge clk) begin : watch
    pfws_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (out_data.kind <= pfws_pkg::K_VERIFY_FAIL) kind_cnt[out_data.kind]++;
      if (bus_beats_q.size() == 0) begin
        report_mismatch("unexpected beat, kind", 20'(out_data.kind), 20'h0);
      end else begin
        want = bus_beats_q.pop_front();
        beats_checked++;
        if (out_data.kind != want.kind)
          report_mismatch("kind", 20'(out_data.kind), 20'(want.kind));
        if (out_data.bus_addr != want.bus_addr)
          report_mismatch("bus_addr", out_data.bus_addr, want.bus_addr);
        if (out_data.bus_data != want.bus_data)
          report_mismatch("bus_data", 20'(out_data.bus_data), 20'(want.bus_data));
        if (out_data.expected != want.expected)
          report_mismatch("expected", 20'(out_data.expected), 20'(want.expected));
        if (out_data.last != want.last)
          report_mismatch("last", 20'(out_data.last), 20'(want.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt, bus_beats_q.size());
      $display("parallel_flash_write_sequencer_tb: FAIL");
      $finish;
    end
  end

  initial begin
    flash_model = reset_state();
    stim_state = reset_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_cmd_set(1'b0);

    // Directed: field extremes, ignored beats, skip, failures, alternate erase
    direct(pfws_pkg::FN_RDATA, 20'hFFFFF, 8'hFF, 8'hFF);
    direct(pfws_pkg::FN_VERIFY, 20'hFFFFF, 8'hFF, 8'h00);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'hFF);
    direct(pfws_pkg::FN_VERIFY, 20'h00000, 8'h00, 8'hFF);
    direct(pfws_pkg::FN_PROG, 20'h12345, 8'h77, 8'h00);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'hA5);
    direct(pfws_pkg::FN_PROG, 20'h12345, 8'h3C, 8'h00);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'h3C);
    direct(pfws_pkg::FN_PROG, 20'hABCDE, 8'h00, 8'h00);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'hFF);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'h40);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'h00);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'h40);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'h00);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'h40);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'hFF);
    direct(pfws_pkg::FN_ERASE, 20'h01234, 8'h00, 8'h00);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'hFF);
    direct(pfws_pkg::FN_ERASE, 20'h01FFF, 8'h00, 8'h00);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'h00);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'h00);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'h00);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'h40);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'h40);
    direct(pfws_pkg::FN_RDATA, 20'h00000, 8'h00, 8'hFF);
    drain();

    // 29xxx set, no idling
    queue_ops(110);
    drain();

    // 28xxx set, sender idling
    set_cmd_set(1'b1);
    idle_pct = 54;
    queue_ops(100);
    drain();

    // 29xxx set, receiver stalling, one long hold-off to back the block up
    set_cmd_set(1'b0);
    idle_pct = 0;
    stall_pct = 54;
    queue_ops(100);
    while (bus_beats_q.size() == 0) @(posedge clk);
    hold_left = 300;
    drain();

    // 28xxx set, both sides idling, sender pauses halfway for a full drain
    set_cmd_set(1'b1);
    idle_pct = 21;
    stall_pct = 21;
    queue_ops(50);
    drain();
    queue_ops(50);
    drain();

    $display("covered %0d input beats (%0d read-data), %0d result beats, both command sets",
             beats_in, rdata_in, beats_checked);
    $display("outcomes: %0d done ok, %0d erase failed, %0d verify failed, %0d mismatches",
             kind_cnt[pfws_pkg::K_OK], kind_cnt[pfws_pkg::K_ERASE_FAIL],
             kind_cnt[pfws_pkg::K_VERIFY_FAIL], errors);
    if (errors == 0) begin
      $display("parallel_flash_write_sequencer_tb: PASS");
    end else begin
      $display("parallel_flash_write_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
